// ===== rtl/eif_pkg.sv =====
`timescale 1ns / 1ps
package eif_pkg;
	localparam int MaxNodes = 32;
	localparam int IdxW     = 5;
	localparam int CntW     = 6;

	typedef enum logic [2:0] {
		REG_D_XX = 3'd0, REG_D_XY = 3'd1, REG_D_XS = 3'd2, REG_D_YY = 3'd3,
		REG_D_YS = 3'd4, REG_D_SS = 3'd5, REG_DENSITY = 3'd6
	} reg_idx_t;

	// node item as queued from front to back
	typedef struct packed {
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		logic signed [31:0] nv;
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] w;
		logic               last;
	} node_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) return 32'sh7fffffff;
		if (x < -66'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	// floor(a*b/2^16); arithmetic shift is floor
	function automatic logic signed [47:0] mulq(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p[63:16];
	endfunction
endpackage

// ===== rtl/element_internal_force_core.sv =====
`timescale 1ns / 1ps
// Plane-elasticity element residual at one quadrature point, Q16.16.
// Channels: s_* carries one node per transfer (tlast marks the element's
//   last node, whose weight is used); m_* returns one force pair per stored
//   node after the last node, tuser holding the node number, tlast the last
//   pair. cfg_* writes D entries (index 0..5) and density (index 6).
// Sequencing: the back-end sequencer takes a node from the queue in ST_IDLE,
//   then runs 3 rows of D*B, each two multiply steps plus accumulate.
//   After the last node, ST_WR and ST_AA set up the mass term, then each
//   pair passes ST_RD, ST_B, ST_F and ST_OUT, where it waits on receiver
//   stall; one shared multiply sequencer does all of these steps.
// A two-entry queue decouples the input side from the sequencer.
// Reset clears accumulators, node count, registers and output valid; the
//   gradient/shape stores are not cleared (only written entries are read).
// When the receiver stalls, the pair holds in the output register and the
//   sequencer waits; the input queue keeps taking up to two nodes.
// At most 32 nodes are stored; further nodes before last are dropped.
module element_internal_force_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// grad_x, grad_y, shape_value, disp_x, disp_y, accel_x, accel_y, weight
	input  logic [255:0] s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// force_x, force_y
	output logic [63:0]  m_tdata,
	// node_index
	output logic [4:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	logic signed [31:0] d_q [6];
	logic signed [31:0] rho_q;
	logic               q_valid, q_ready;
	eif_pkg::node_t     q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) d_q[i] <= '0;
			rho_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				eif_pkg::REG_D_XX:    d_q[0] <= cfg_data;
				eif_pkg::REG_D_XY:    d_q[1] <= cfg_data;
				eif_pkg::REG_D_XS:    d_q[2] <= cfg_data;
				eif_pkg::REG_D_YY:    d_q[3] <= cfg_data;
				eif_pkg::REG_D_YS:    d_q[4] <= cfg_data;
				eif_pkg::REG_D_SS:    d_q[5] <= cfg_data;
				eif_pkg::REG_DENSITY: rho_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	eif_front u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tlast(s_tlast),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	eif_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_data(q_data), .d_q(d_q), .rho(rho_q),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);
endmodule

// ===== rtl/eif_ram.sv =====
`timescale 1ns / 1ps
module eif_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/eif_queue.sv =====
`timescale 1ns / 1ps
// two-entry queue between front and back
module eif_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  eif_pkg::node_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output eif_pkg::node_t out_data
);
	eif_pkg::node_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push, pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/eif_front.sv =====
`timescale 1ns / 1ps
// unpacks input transfers into node items
module eif_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [255:0]   s_tdata,
	input  logic           s_tlast,
	output logic           q_valid,
	input  logic           q_ready,
	output eif_pkg::node_t q_data
);
	eif_pkg::node_t node;
	always_comb begin
		node.gx = s_tdata[31:0];
		node.gy = s_tdata[63:32];
		node.nv = s_tdata[95:64];
		node.ux = s_tdata[127:96];
		node.uy = s_tdata[159:128];
		node.ax = s_tdata[191:160];
		node.ay = s_tdata[223:192];
		node.w  = s_tdata[255:224];
		node.last = s_tlast;
	end
	eif_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(node),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
	);
endmodule

// ===== rtl/eif_back.sv =====
`timescale 1ns / 1ps
// sequencer: accumulate one node over several steps, then emit pass
module eif_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  eif_pkg::node_t     q_data,
	input  logic signed [31:0] d_q [6],
	input  logic signed [31:0] rho,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [63:0]        m_tdata,
	output logic [4:0]         m_tuser,
	output logic               m_tlast
);
	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001, ST_DB   = 10'b0000000010,
		ST_DBA  = 10'b0000000100, ST_ACC  = 10'b0000001000,
		ST_WR   = 10'b0000010000, ST_AA   = 10'b0000100000,
		ST_RD   = 10'b0001000000, ST_B    = 10'b0010000000,
		ST_F    = 10'b0100000000, ST_OUT  = 10'b1000000000
	} state_t;

	state_t                     state_q;
	eif_pkg::node_t             n_q;
	logic [1:0]                 k_q;
	logic [eif_pkg::CntW-1:0]   cnt_q, i_q;
	logic signed [63:0]         sacc_q [3];
	logic signed [63:0]         aacc_q [2];
	logic signed [47:0]         p0_q, p1_q, p2_q, p3_q;
	logic signed [31:0]         wr_q, aax_q, aay_q, bx_q, by_q;
	logic signed [31:0]         s0, s1, s2, c0, c1, c2, db0, db1;
	logic [63:0]                g_rd;
	logic [31:0]                n_rd;
	logic                       we;

	assign s0 = eif_pkg::sat32(66'(sacc_q[0]));
	assign s1 = eif_pkg::sat32(66'(sacc_q[1]));
	assign s2 = eif_pkg::sat32(66'(sacc_q[2]));

	// D row k: (xx,xy,xs),(xy,yy,ys),(xs,ys,ss); d_q order xx,xy,xs,yy,ys,ss
	always_comb begin
		case (k_q)
			2'd0:    begin c0 = d_q[0]; c1 = d_q[1]; c2 = d_q[2]; end
			2'd1:    begin c0 = d_q[1]; c1 = d_q[3]; c2 = d_q[4]; end
			default: begin c0 = d_q[2]; c1 = d_q[4]; c2 = d_q[5]; end
		endcase
	end
	assign db0 = eif_pkg::sat32(66'(p0_q) + 66'(p1_q));
	assign db1 = eif_pkg::sat32(66'(p2_q) + 66'(p3_q));

	assign we = state_q == ST_IDLE && q_valid && cnt_q != 6'(eif_pkg::MaxNodes);
	assign q_ready = state_q == ST_IDLE;

	eif_ram #(.Width(64), .Depth(eif_pkg::MaxNodes)) u_grad (
		.clk(clk), .we(we), .waddr(cnt_q[eif_pkg::IdxW-1:0]),
		.wdata({q_data.gy, q_data.gx}), .raddr(i_q[eif_pkg::IdxW-1:0]), .rdata(g_rd));
	eif_ram #(.Width(32), .Depth(eif_pkg::MaxNodes)) u_shape (
		.clk(clk), .we(we), .waddr(cnt_q[eif_pkg::IdxW-1:0]),
		.wdata(q_data.nv), .raddr(i_q[eif_pkg::IdxW-1:0]), .rdata(n_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; cnt_q <= '0; i_q <= '0; k_q <= '0;
			sacc_q[0] <= '0; sacc_q[1] <= '0; sacc_q[2] <= '0;
			aacc_q[0] <= '0; aacc_q[1] <= '0; m_tvalid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (q_valid) begin
					n_q <= q_data; k_q <= '0;
					if (cnt_q != 6'(eif_pkg::MaxNodes)) begin
						cnt_q <= cnt_q + 6'd1;
						state_q <= ST_DB;
					end else if (q_data.last) state_q <= ST_WR;
				end
				ST_DB: begin
					p0_q <= eif_pkg::mulq(c0, n_q.gx);
					p1_q <= eif_pkg::mulq(c2, n_q.gy);
					p2_q <= eif_pkg::mulq(c1, n_q.gy);
					p3_q <= eif_pkg::mulq(c2, n_q.gx);
					state_q <= ST_DBA;
				end
				ST_DBA: begin
					p0_q <= eif_pkg::mulq(db0, n_q.ux);
					p1_q <= eif_pkg::mulq(db1, n_q.uy);
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sacc_q[k_q] <= sacc_q[k_q] + 64'(p0_q) + 64'(p1_q);
					if (k_q != 2'd2) begin
						k_q <= k_q + 2'd1; state_q <= ST_DB;
					end else begin
						aacc_q[0] <= aacc_q[0] + 64'(eif_pkg::mulq(n_q.nv, n_q.ax));
						aacc_q[1] <= aacc_q[1] + 64'(eif_pkg::mulq(n_q.nv, n_q.ay));
						state_q <= n_q.last ? ST_WR : ST_IDLE;
					end
				end
				ST_WR: begin
					wr_q <= eif_pkg::sat32(66'(eif_pkg::mulq(n_q.w, rho)));
					state_q <= ST_AA;
				end
				ST_AA: begin
					aax_q <= eif_pkg::sat32(66'(eif_pkg::mulq(
						eif_pkg::sat32(66'(aacc_q[0])), wr_q)));
					aay_q <= eif_pkg::sat32(66'(eif_pkg::mulq(
						eif_pkg::sat32(66'(aacc_q[1])), wr_q)));
					i_q <= '0;
					state_q <= (cnt_q == '0) ? ST_IDLE : ST_RD;
					if (cnt_q == '0) begin
						sacc_q[0] <= '0; sacc_q[1] <= '0; sacc_q[2] <= '0;
						aacc_q[0] <= '0; aacc_q[1] <= '0;
					end
				end
				ST_RD: state_q <= ST_B;
				ST_B: begin
					bx_q <= eif_pkg::sat32(66'(eif_pkg::mulq(g_rd[31:0], s0))
						+ 66'(eif_pkg::mulq(g_rd[63:32], s2)));
					by_q <= eif_pkg::sat32(66'(eif_pkg::mulq(g_rd[63:32], s1))
						+ 66'(eif_pkg::mulq(g_rd[31:0], s2)));
					state_q <= ST_F;
				end
				ST_F: begin
					m_tdata[31:0] <= eif_pkg::sat32(66'(eif_pkg::mulq(bx_q, n_q.w))
						+ 66'(eif_pkg::mulq(n_rd, aax_q)));
					m_tdata[63:32] <= eif_pkg::sat32(66'(eif_pkg::mulq(by_q, n_q.w))
						+ 66'(eif_pkg::mulq(n_rd, aay_q)));
					m_tuser <= i_q[eif_pkg::IdxW-1:0];
					m_tlast <= (i_q + 6'd1) == cnt_q;
					m_tvalid <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: if (m_tready) begin
					m_tvalid <= 1'b0;
					if ((i_q + 6'd1) == cnt_q) begin
						cnt_q <= '0;
						sacc_q[0] <= '0; sacc_q[1] <= '0; sacc_q[2] <= '0;
						aacc_q[0] <= '0; aacc_q[1] <= '0;
						state_q <= ST_IDLE;
					end else begin
						i_q <= i_q + 6'd1; state_q <= ST_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
